[rtl/npc_pkg.sv]
// Shared types and constants for the nearest palette color search.
package npc_pkg;

    localparam int CHAN_W = 8;
    localparam int SQ_W   = 2 * CHAN_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int COLOR_W = 3 * CHAN_W;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;
        logic start;
        logic issue;
        logic load_out;
    } npc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic addr_last;
        logic pipe_busy;
    } npc_status_t;

endpackage

[rtl/npc_ctrl.sv]
// Controller state machine for the nearest palette color search.
module npc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  npc_pkg::npc_status_t status,
    output npc_pkg::npc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_beat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.wr_en    = 1'b0;
        cmd.start    = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (req_type == npc_pkg::REQ_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && req_type == npc_pkg::REQ_QUERY) |=> (state_reg == ST_SCAN))
        else $error("query beat did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && !status.pipe_busy) |=> (state_reg == ST_RESULT))
        else $error("drained scan did not reach result state");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && (cmd.issue || cmd.start)))
        else $error("palette write during a scan");

endmodule

[rtl/npc_dp.sv]
// Datapath: palette memory, distance pipeline, running minimum and result register.
module npc_dp
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  npc_pkg::npc_cmd_t            cmd,
    output npc_pkg::npc_status_t         status,
    input  logic [7:0]                   entry_index,
    input  logic [npc_pkg::CHAN_W-1:0]   red,
    input  logic [npc_pkg::CHAN_W-1:0]   green,
    input  logic [npc_pkg::CHAN_W-1:0]   blue,
    output logic [7:0]                   color_index
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

    logic [npc_pkg::COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];

    logic [AW-1:0]                 addr_reg;
    logic [AW-1:0]                 addr_next;
    logic [npc_pkg::CHAN_W-1:0]    tgt_r_reg;
    logic [npc_pkg::CHAN_W-1:0]    tgt_g_reg;
    logic [npc_pkg::CHAN_W-1:0]    tgt_b_reg;
    logic [npc_pkg::COLOR_W-1:0]   rdata_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic [AW-1:0]                 idx1_reg;
    logic [AW-1:0]                 idx2_reg;
    logic [npc_pkg::SQ_W-1:0]      sq_r_reg;
    logic [npc_pkg::SQ_W-1:0]      sq_g_reg;
    logic [npc_pkg::SQ_W-1:0]      sq_b_reg;
    logic [npc_pkg::DIST_W-1:0]    best_dist_reg;
    logic [AW-1:0]                 best_idx_reg;
    logic                          best_found_reg;
    logic [7:0]                    color_index_reg;

    logic [npc_pkg::CHAN_W-1:0]    diff_r;
    logic [npc_pkg::CHAN_W-1:0]    diff_g;
    logic [npc_pkg::CHAN_W-1:0]    diff_b;
    logic [npc_pkg::DIST_W-1:0]    dist_sum;
    logic                          take;
    logic                          wr_in_range;

    assign status.addr_last = (addr_reg == LAST_ADDR);
    assign status.pipe_busy = v1_reg || v2_reg;
    assign color_index      = color_index_reg;

    assign wr_in_range = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));

    // palette write and registered scan read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            palette_mem[entry_index[AW-1:0]] <= {red, green, blue};
        end
        if (cmd.issue)
        begin
            rdata_reg <= palette_mem[addr_reg];
        end
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.start)
        begin
            addr_next = '0;
        end
        else if (cmd.issue)
        begin
            addr_next = addr_reg + AW'(1);
        end
    end

    always_comb
    begin
        diff_r = (rdata_reg[23:16] >= tgt_r_reg) ? rdata_reg[23:16] - tgt_r_reg
                                                 : tgt_r_reg - rdata_reg[23:16];
        diff_g = (rdata_reg[15:8] >= tgt_g_reg) ? rdata_reg[15:8] - tgt_g_reg
                                                : tgt_g_reg - rdata_reg[15:8];
        diff_b = (rdata_reg[7:0] >= tgt_b_reg) ? rdata_reg[7:0] - tgt_b_reg
                                               : tgt_b_reg - rdata_reg[7:0];
    end

    assign dist_sum = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                    + npc_pkg::DIST_W'(sq_b_reg);
    // strict compare keeps the lowest index on ties
    assign take = v2_reg && (!best_found_reg || (dist_sum < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            if (cmd.start)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            tgt_r_reg <= red;
            tgt_g_reg <= green;
            tgt_b_reg <= blue;
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        sq_r_reg <= diff_r * diff_r;
        sq_g_reg <= diff_g * diff_g;
        sq_b_reg <= diff_b * diff_b;
        if (take)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= idx2_reg;
        end
        if (cmd.load_out)
        begin
            color_index_reg <= 8'(best_idx_reg);
        end
    end

endmodule

[rtl/nearest_palette_color.sv]
// Top level of the nearest palette color search.
//
// Input channel (in_valid / in_stall) carries one beat per request. With
// req_type low the beat writes red, green and blue into palette entry
// entry_index; writes at or beyond PALETTE_ENTRIES are dropped. A write gives
// no result. With req_type high the beat is a query: the block reads every
// palette entry, one per cycle from the palette memory, and returns on the
// output channel (out_valid / out_stall) the index of the entry with the
// smallest squared RGB distance, lowest index on ties.
// A query keeps the input stalled through the scan, the pipeline flush and
// the result load, so no new beat is taken until the query is done; the
// one-read-per-cycle memory scan makes up most of a query.
// The result sits in an output register, so new beats are taken while it
// waits. If the receiver still stalls when the next query finishes, that
// query holds its result and stalls the input until the register frees.
// Reset clears the control state; the palette is undefined until written.
module nearest_palette_color
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] entry_index,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] color_index
);

    npc_pkg::npc_cmd_t    cmd;
    npc_pkg::npc_status_t status;

    npc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    npc_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .color_index (color_index)
    );

endmodule

[tb/npc_checker.sv]
// Checker for the nearest palette color search: predicts every query result and compares it.
`timescale 1ns / 1ps
module npc_checker
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] entry_index,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] color_index,
    output int         errors,
    output int         pending
);

    localparam logic [31:0] START_DIST = 32'h7FFF_FFFF;

    logic [npc_pkg::COLOR_W-1:0] palette_copy [PALETTE_ENTRIES];
    logic [7:0]                  nearest_q [$];
    int                          err_count = 0;

    function automatic logic [npc_pkg::DIST_W-1:0] chan_sq(
        logic [npc_pkg::CHAN_W-1:0] a,
        logic [npc_pkg::CHAN_W-1:0] b
    );
        logic [npc_pkg::CHAN_W-1:0] d;
        d = (a >= b) ? a - b : b - a;
        return npc_pkg::DIST_W'(d) * npc_pkg::DIST_W'(d);
    endfunction

    // Scan the whole palette; strict less-than keeps the lowest index on a tie.
    function automatic logic [7:0] nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [31:0]                 best_dist;
        logic [7:0]                  best_idx;
        logic [npc_pkg::DIST_W-1:0]  cand_dist;
        logic [npc_pkg::COLOR_W-1:0] e;
        best_dist = START_DIST;
        best_idx  = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            e         = palette_copy[i];
            cand_dist = chan_sq(e[23:16], r) + chan_sq(e[15:8], g) + chan_sq(e[7:0], b);
            if (32'(cand_dist) < best_dist)
            begin
                best_dist = 32'(cand_dist);
                best_idx  = 8'(i);
            end
        end
        return best_idx;
    endfunction

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n)
        begin
            // check the output first so a result never matches a query taken this cycle
            if (out_valid && !out_stall)
            begin
                if (nearest_q.size() == 0)
                begin
                    $error("color_index: result with none expected, actual %0d", color_index);
                    err_count++;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (color_index !== want)
                    begin
                        $error("color_index mismatch: expected %0d, actual %0d", want, color_index);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == npc_pkg::REQ_WRITE)
                begin
                    if (entry_index < PALETTE_ENTRIES)
                        palette_copy[entry_index] = {red, green, blue};
                end
                else
                    nearest_q.push_back(nearest_entry(red, green, blue));
            end
        end
        errors  <= err_count;
        pending <= nearest_q.size();
    end

endmodule

[tb/tb.sv]
// Top of the nearest palette color testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

    localparam int PALETTE_ENTRIES = 256;
    localparam int RUN_LIMIT       = 1_500_000;
    localparam int LONG_HOLD       = 1200;
    localparam int PHASE_ITEMS     = 205;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic       req_type    = npc_pkg::REQ_WRITE;
    logic [7:0] entry_index = '0;
    logic [7:0] red         = '0;
    logic [7:0] green       = '0;
    logic [7:0] blue        = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] color_index;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    bit long_hold     = 1'b0;

    logic [23:0] painted [PALETTE_ENTRIES];
    logic [23:0] shades [8] = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000,
                                24'h00FF00, 24'h0000FF, 24'h7F7F80, 24'h404040};

    nearest_palette_color #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_index (color_index)
    );

    npc_checker #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_index (color_index),
        .errors      (fail_count),
        .pending     (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= long_hold || ($urandom_range(99) < stall_pct);

    // Hold the receiver off long enough for the block to back up into its input.
    initial
    begin
        wait (hold_req);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
    end

    task automatic send_beat(input logic kind, input logic [7:0] idx, input logic [23:0] rgb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        entry_index <= idx;
        red         <= rgb[23:16];
        green       <= rgb[15:8];
        blue        <= rgb[7:0];
        if (kind == npc_pkg::REQ_WRITE)
            painted[idx] = rgb;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_item;
        logic [23:0] c;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            if ($urandom_range(1) != 0)
                c = shades[$urandom_range(7)];
            else
                c = 24'($urandom());
            send_beat(npc_pkg::REQ_WRITE, 8'($urandom_range(PALETTE_ENTRIES - 1)), c);
        end
        else
        begin
            case ($urandom_range(2))
                0: c = painted[$urandom_range(PALETTE_ENTRIES - 1)];
                1:
                begin
                    c = shades[$urandom_range(7)];
                    c[23:16] = c[23:16] + 8'($urandom_range(6)) - 8'd3;
                    c[15:8]  = c[15:8] + 8'($urandom_range(6)) - 8'd3;
                    c[7:0]   = c[7:0] + 8'($urandom_range(6)) - 8'd3;
                end
                default: c = 24'($urandom());
            endcase
            send_beat(npc_pkg::REQ_QUERY, 8'($urandom()), c);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every entry with mid gray so a mid-gray query ties across every gray entry
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            send_beat(npc_pkg::REQ_WRITE, 8'(i), 24'h808080);

        send_beat(npc_pkg::REQ_WRITE, 8'd0, 24'h000000);
        send_beat(npc_pkg::REQ_WRITE, 8'd255, 24'hFFFFFF);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'h000000);
        send_beat(npc_pkg::REQ_QUERY, 8'h00, 24'hFFFFFF);
        send_beat(npc_pkg::REQ_QUERY, 8'hA5, 24'h808080);
        send_beat(npc_pkg::REQ_WRITE, 8'd7, 24'hFF0000);
        send_beat(npc_pkg::REQ_WRITE, 8'd200, 24'hFF0000);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'hFF0000);
        send_beat(npc_pkg::REQ_QUERY, 8'h5A, 24'hFA0302);
        send_beat(npc_pkg::REQ_WRITE, 8'd128, 24'h00FF00);
        send_beat(npc_pkg::REQ_WRITE, 8'd64, 24'h0000FF);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'h00FF00);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'h0000FF);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'hFFFF00);
        // duplicate black at the top entry: lowest index must still win
        send_beat(npc_pkg::REQ_WRITE, 8'd255, 24'h000000);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'h000000);
        send_beat(npc_pkg::REQ_WRITE, 8'd0, 24'hFFFFFF);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'h000000);
        send_beat(npc_pkg::REQ_QUERY, 8'hFF, 24'hFFFFFF);
        wait_drained();

        // back the block up behind a stalled receiver
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_beat(npc_pkg::REQ_QUERY, 8'($urandom()), 24'($urandom()));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct <= 0;
                    stall_pct     <= 0;
                end
                1:
                begin
                    send_idle_pct <= 84;
                    stall_pct     <= 0;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    stall_pct     <= 84;
                end
                default:
                begin
                    send_idle_pct <= 11;
                    stall_pct     <= 11;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
            wait_drained();
        end

        repeat (PALETTE_ENTRIES + 10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
